// ===== src/rvmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rvmm_pkg
// Shared types and constants of the row vector by matrix multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvmm_pkg;

  localparam int unsigned DEFAULT_MAX_LENGTH  = 64;
  localparam int unsigned DEFAULT_MAX_COLUMNS = 64;

  localparam int unsigned ROW_W  = 6;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CFG_W  = 7;

  // largest number of entries the 6-bit indexes can reach
  localparam int unsigned INDEX_SPAN = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_MATRIX = 1'b1
  } func_e;

  typedef enum logic {
    REG_VECTOR_LENGTH = 1'b0,
    REG_COLUMN_COUNT  = 1'b1
  } reg_idx_e;

  // control carried along the pipeline with each matrix or error beat
  typedef struct packed {
    logic             err;
    logic             last;
    logic [COL_W-1:0] col;
  } stage_t;

  // accumulate stage outcome
  typedef struct packed {
    logic             we;
    logic             valid;
    logic             err;
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] sum;
  } mac_res_t;

endpackage

`default_nettype wire

// ===== src/rvmm_ram.sv =====
// ----------------------------------------------------------------------------
// rvmm_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rvmm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/rvmm_mac.sv =====
// ----------------------------------------------------------------------------
// rvmm_mac
// Accumulate stage: saturating add of the product and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module rvmm_mac (
  input  wire logic                                valid_i,
  input  wire rvmm_pkg::stage_t                    ctrl_i,
  input  wire logic        [rvmm_pkg::SUM_W-1:0]   acc_i,
  input  wire logic signed [rvmm_pkg::PROD_W-1:0]  prod_i,
  output logic             [rvmm_pkg::SUM_W-1:0]   wdata_o,
  output rvmm_pkg::mac_res_t                       res_o
);

  localparam int unsigned SW = rvmm_pkg::SUM_W;

  logic [SW:0]   sum_ext;
  logic [SW-1:0] sum_sat;

  assign sum_ext = {acc_i[SW-1], acc_i} + (SW+1)'(prod_i);

  always_comb begin
    // top two bits differ on overflow
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_sat = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SW-1:0];
    end
  end

  // finished column restarts from zero
  assign wdata_o = ctrl_i.last ? '0 : sum_sat;

  assign res_o.we    = valid_i && !ctrl_i.err;
  assign res_o.valid = valid_i && (ctrl_i.err || ctrl_i.last);
  assign res_o.err   = ctrl_i.err;
  assign res_o.col   = ctrl_i.err ? '0 : ctrl_i.col;
  assign res_o.sum   = ctrl_i.err ? '0 : sum_sat;

endmodule

`default_nettype wire

// ===== src/row_vector_matrix_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// row_vector_matrix_multiply_unit
// Streams matrix elements against a stored row vector into column sums.
// ----------------------------------------------------------------------------
// Input beats (valid/ready) either load one vector element (func 0) or carry
// one matrix element with its row and column (func 1). A matrix beat adds
// vector[row] * value into the accumulator of its column; the beat on the
// last row returns that column's Q32.16 sum and clears the accumulator.
// Out-of-range indexes return an error beat and change nothing. Loads in
// range return nothing.
// The configuration port sets vector_length and column_count; write it only
// while the unit is idle.
// Throughput is one beat per cycle unless the receiver stalls. The vector
// and accumulator RAMs are read at acceptance, stage one multiplies, stage
// two adds with saturation and writes back, then the output register.
// Accumulator reads that overlap a pending write are served by forwarding.
// Reset sets both registers to 64 and clears the accumulators through
// per-entry valid bits, so no clearing pass is needed. Vector entries hold
// nothing until loaded.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module row_vector_matrix_multiply_unit #(
  parameter int unsigned MAX_LENGTH  = rvmm_pkg::DEFAULT_MAX_LENGTH,
  parameter int unsigned MAX_COLUMNS = rvmm_pkg::DEFAULT_MAX_COLUMNS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,

  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_index_i,
  input  wire logic        [rvmm_pkg::CFG_W-1:0]    cfg_data_i,

  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 func_i,
  input  wire logic        [rvmm_pkg::ROW_W-1:0]    row_index_i,
  input  wire logic        [rvmm_pkg::COL_W-1:0]    col_index_i,
  input  wire logic signed [rvmm_pkg::VAL_W-1:0]    value_i,

  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic             [rvmm_pkg::COL_W-1:0]    result_column_o,
  output logic signed      [rvmm_pkg::SUM_W-1:0]    product_sum_o,
  output logic                                      index_error_o
);

  localparam int unsigned CW = rvmm_pkg::CFG_W;
  localparam int unsigned SW = rvmm_pkg::SUM_W;
  localparam int unsigned VW = rvmm_pkg::VAL_W;
  localparam int unsigned PW = rvmm_pkg::PROD_W;

  localparam int unsigned SPAN      = rvmm_pkg::INDEX_SPAN;
  localparam int unsigned VEC_DEPTH = (MAX_LENGTH < SPAN) ? MAX_LENGTH : SPAN;
  localparam int unsigned ACC_DEPTH = (MAX_COLUMNS < SPAN) ? MAX_COLUMNS : SPAN;
  localparam int unsigned VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int unsigned ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int unsigned CFG_MAX   = (1 << CW) - 1;
  localparam logic [CW-1:0] LEN_CAP =
    CW'((MAX_LENGTH > CFG_MAX) ? CFG_MAX : MAX_LENGTH);
  localparam logic [CW-1:0] COL_CAP =
    CW'((MAX_COLUMNS > CFG_MAX) ? CFG_MAX : MAX_COLUMNS);

  // configuration
  logic [CW-1:0] vlen_q, cols_q;
  logic [CW-1:0] eff_len, eff_cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= rvmm_pkg::CFG_RESET;
      cols_q <= rvmm_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (rvmm_pkg::reg_idx_e'(cfg_index_i))
        rvmm_pkg::REG_VECTOR_LENGTH: vlen_q <= cfg_data_i;
        rvmm_pkg::REG_COLUMN_COUNT:  cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_len  = (vlen_q > LEN_CAP) ? LEN_CAP : vlen_q;
  assign eff_cols = (cols_q > COL_CAP) ? COL_CAP : cols_q;

  // pipeline control
  logic out_valid_q;
  logic adv;
  logic in_acc;
  logic is_mat, row_err, col_err, in_err, is_last;
  logic load_we, mat_go;

  assign adv        = !(out_valid_q && !out_ready_i);
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_mat  = (rvmm_pkg::func_e'(func_i) == rvmm_pkg::FUNC_MATRIX);
  assign row_err = ({1'b0, row_index_i} >= eff_len);
  assign col_err = ({1'b0, col_index_i} >= eff_cols);
  assign in_err  = row_err || (is_mat && col_err);
  assign is_last = (({1'b0, row_index_i} + 1'b1) == eff_len);
  assign load_we = in_acc && !is_mat && !row_err;
  assign mat_go  = in_acc && is_mat && !in_err;

  // vector store
  logic [VW-1:0] vec_rdata;

  rvmm_ram #(
    .WIDTH (VW),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (row_index_i[VEC_AW-1:0]),
    .wdata_i (value_i),
    .re_i    (mat_go),
    .raddr_i (row_index_i[VEC_AW-1:0]),
    .rdata_o (vec_rdata)
  );

  // accumulator store with reset valid bits
  logic [SW-1:0]       acc_rdata;
  logic [SW-1:0]       acc_wdata;
  logic                acc_we;
  rvmm_pkg::stage_t    s2_ctrl_q;
  logic [ACC_DEPTH-1:0] acc_vld_q;

  rvmm_ram #(
    .WIDTH (SW),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (s2_ctrl_q.col[ACC_AW-1:0]),
    .wdata_i (acc_wdata),
    .re_i    (mat_go),
    .raddr_i (col_index_i[ACC_AW-1:0]),
    .rdata_o (acc_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (acc_we) begin
      acc_vld_q[s2_ctrl_q.col[ACC_AW-1:0]] <= 1'b1;
    end
  end

  // stage 1: RAM data back, multiply, forward
  logic                   s1_valid_q;
  rvmm_pkg::stage_t       s1_ctrl_q;
  logic signed [VW-1:0]   s1_value_q;
  logic                   s1_accv_q;
  logic signed [PW-1:0]   prod_s1;
  logic [SW-1:0]          acc_fwd;

  logic                   s2_valid_q;
  logic [SW-1:0]          s2_acc_q;
  logic signed [PW-1:0]   s2_prod_q;

  logic                           wb_vld_q;
  logic [rvmm_pkg::COL_W-1:0]     wb_col_q;
  logic [SW-1:0]                  wb_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wb_vld_q   <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q <= in_acc && (is_mat || in_err);
        s2_valid_q <= s1_valid_q;
      end
      if (acc_we) begin
        wb_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctrl_q.err  <= in_err;
      s1_ctrl_q.last <= is_last;
      s1_ctrl_q.col  <= col_index_i;
      s1_value_q     <= value_i;
      s2_ctrl_q      <= s1_ctrl_q;
      s2_acc_q       <= acc_fwd;
      s2_prod_q      <= prod_s1;
    end
    if (mat_go) begin
      s1_accv_q <= acc_vld_q[col_index_i[ACC_AW-1:0]];
    end
    if (acc_we) begin
      wb_col_q  <= s2_ctrl_q.col;
      wb_data_q <= acc_wdata;
    end
  end

  assign prod_s1 = $signed(vec_rdata) * s1_value_q;

  // newest write wins: the one in flight, then the last one, then the RAM, else zero
  always_comb begin
    priority if (acc_we && (s2_ctrl_q.col == s1_ctrl_q.col)) begin
      acc_fwd = acc_wdata;
    end else if (wb_vld_q && (wb_col_q == s1_ctrl_q.col)) begin
      acc_fwd = wb_data_q;
    end else if (s1_accv_q) begin
      acc_fwd = acc_rdata;
    end else begin
      acc_fwd = '0;
    end
  end

  // stage 2: accumulate and write back
  rvmm_pkg::mac_res_t mac_res;

  rvmm_mac u_mac (
    .valid_i (s2_valid_q && adv),
    .ctrl_i  (s2_ctrl_q),
    .acc_i   (s2_acc_q),
    .prod_i  (s2_prod_q),
    .wdata_o (acc_wdata),
    .res_o   (mac_res)
  );

  assign acc_we = mac_res.we;

  // output register
  logic [rvmm_pkg::COL_W-1:0] out_col_q;
  logic [SW-1:0]              out_sum_q;
  logic                       out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mac_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_res.valid) begin
      out_col_q <= mac_res.col;
      out_sum_q <= mac_res.sum;
      out_err_q <= mac_res.err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_column_o = out_col_q;
  assign product_sum_o   = $signed(out_sum_q);
  assign index_error_o   = out_err_q;

  // checks
  a_stall_only_on_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o
  ) else $error("input stalled without a waiting result");

  a_error_enters_pipe: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_err) |=> (s1_valid_q && s1_ctrl_q.err)
  ) else $error("error beat lost at stage one");

  a_error_result_clean: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_error_o) |-> (result_column_o == '0 && product_sum_o == '0)
  ) else $error("error result carries data");

endmodule

`default_nettype wire
